FILE: rtl/perfect_power_test_assert.svh
// assertion macros used by the checker file
`ifndef PERFECT_POWER_TEST_ASSERT_SVH
`define PERFECT_POWER_TEST_ASSERT_SVH

// same-cycle implication, off while reset is high
`define PPT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("perfect_power_test: check failed");

// next-cycle implication, off while reset is high
`define PPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("perfect_power_test: check failed");

// next-cycle implication that also holds through reset
`define PPT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("perfect_power_test: check failed");

`endif

FILE: rtl/ppt_pkg.sv
package ppt_pkg;

   // width of the tested value
   localparam int VALUE_BITS = 31;
   // widest root that can matter (square root of the largest value)
   localparam int ROOT_BITS  = (VALUE_BITS + 1) / 2;
   localparam int BIT_W      = (ROOT_BITS > 1) ? $clog2(ROOT_BITS) : 1;
   localparam int EXP_W      = $clog2(VALUE_BITS + 1);
   localparam int PROD_BITS  = VALUE_BITS + ROOT_BITS;

   // primality by repeated addition, elaboration only
   function automatic bit is_prime_const(int n);
      int d;
      int m;
      bit pr;
      pr = (n >= 2);
      for (d = 2; d < n; d++) begin
         m = d;
         while (m < n) m = m + d;
         if (m == n) pr = 1'b0;
      end
      return pr;
   endfunction

   function automatic int count_primes();
      int n;
      int c;
      c = 0;
      for (n = 2; n <= VALUE_BITS; n++) begin
         if (is_prime_const(n)) c = c + 1;
      end
      return c;
   endfunction

   // only prime exponents need a try: a composite power is also a prime power
   localparam int PRIME_COUNT = count_primes();
   localparam int PIDX_W      = (PRIME_COUNT > 1) ? $clog2(PRIME_COUNT) : 1;

   typedef logic [PRIME_COUNT-1:0][EXP_W-1:0] exp_table_type;
   typedef logic [PRIME_COUNT-1:0][BIT_W-1:0] bit_table_type;

   function automatic exp_table_type build_primes();
      exp_table_type t;
      int n;
      int k;
      t = '0;
      k = 0;
      for (n = 2; n <= VALUE_BITS; n++) begin
         if (is_prime_const(n)) begin
            t[k] = EXP_W'(n);
            k = k + 1;
         end
      end
      return t;
   endfunction

   localparam exp_table_type PRIMES = build_primes();

   // top root bit per exponent: ceil(VALUE_BITS / p) - 1
   function automatic bit_table_type build_start_bits();
      bit_table_type t;
      int k;
      int p;
      int r;
      t = '0;
      for (k = 0; k < PRIME_COUNT; k++) begin
         p = int'(PRIMES[k]);
         r = 0;
         while (r * p < VALUE_BITS) r = r + 1;
         t[k] = BIT_W'(r - 1);
      end
      return t;
   endfunction

   localparam bit_table_type START_BITS = build_start_bits();

   // controller to datapath
   typedef struct packed {
      logic load_value;
      logic init_exp;
      logic init_bit;
      logic start_trial;
      logic mul;
      logic check;
      logic keep_root;
      logic next_bit;
      logic next_exp;
      logic set_hit;
   } ppt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic value_zero;
      logic over;
      logic pow_last;
      logic exact;
      logic bit_last;
      logic exp_last;
   } ppt_status_type;

endpackage

FILE: rtl/ppt_datapath.sv
module ppt_datapath (
   input  logic                              clock,
   input  logic [ppt_pkg::VALUE_BITS-1:0]    req_value,
   input  ppt_pkg::ppt_cmd_type              cmd,
   output ppt_pkg::ppt_status_type           status,
   output logic                              hit
);

   logic [ppt_pkg::VALUE_BITS-1:0] value_ff, value_in;
   logic [ppt_pkg::VALUE_BITS-1:0] acc_ff, acc_in;
   logic [ppt_pkg::PROD_BITS-1:0]  prod_ff, prod_in;
   logic [ppt_pkg::ROOT_BITS-1:0]  cand_ff, cand_in;
   logic [ppt_pkg::ROOT_BITS-1:0]  root_ff, root_in;
   logic [ppt_pkg::BIT_W-1:0]      bit_ff, bit_in;
   logic [ppt_pkg::EXP_W-1:0]      cnt_ff, cnt_in;
   logic [ppt_pkg::PIDX_W-1:0]     pidx_ff, pidx_in;
   logic                           hit_ff, hit_in;
   logic [ppt_pkg::EXP_W-1:0]      cur_exp;

   assign cur_exp = ppt_pkg::PRIMES[pidx_ff];

   // exponent and root-bit walk
   always_comb begin
      pidx_in = pidx_ff;
      bit_in  = bit_ff;
      root_in = root_ff;
      if (cmd.init_exp) begin
         pidx_in = '0;
      end else if (cmd.next_exp) begin
         pidx_in = pidx_ff + ppt_pkg::PIDX_W'(1);
      end
      if (cmd.init_bit) begin
         bit_in  = ppt_pkg::START_BITS[pidx_ff];
         root_in = '0;
      end else if (cmd.next_bit) begin
         bit_in  = bit_ff - ppt_pkg::BIT_W'(1);
      end
      if (cmd.keep_root) begin
         root_in = cand_ff;
      end
   end

   // power of the candidate, one multiply then one compare per step
   always_comb begin
      value_in = value_ff;
      cand_in  = cand_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      hit_in   = hit_ff;
      if (cmd.load_value) begin
         value_in = req_value;
         hit_in   = 1'b0;
      end
      if (cmd.start_trial) begin
         cand_in = root_ff | (ppt_pkg::ROOT_BITS'(1) << bit_ff);
         acc_in  = ppt_pkg::VALUE_BITS'(1);
         cnt_in  = '0;
      end
      if (cmd.mul) begin
         prod_in = ppt_pkg::PROD_BITS'(acc_ff) * ppt_pkg::PROD_BITS'(cand_ff);
      end
      if (cmd.check) begin
         acc_in = prod_ff[ppt_pkg::VALUE_BITS-1:0];
         cnt_in = cnt_ff + ppt_pkg::EXP_W'(1);
      end
      if (cmd.set_hit) begin
         hit_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      cand_ff  <= cand_in;
      root_ff  <= root_in;
      bit_ff   <= bit_in;
      cnt_ff   <= cnt_in;
      pidx_ff  <= pidx_in;
      hit_ff   <= hit_in;
   end

   // status back to the controller
   always_comb begin
      status.value_zero = (value_ff == '0);
      status.over       = (prod_ff > ppt_pkg::PROD_BITS'(value_ff));
      status.pow_last   = (cnt_ff == cur_exp - ppt_pkg::EXP_W'(1));
      status.exact      = (acc_ff == value_ff);
      status.bit_last   = (bit_ff == '0);
      status.exp_last   = (pidx_ff == ppt_pkg::PIDX_W'(ppt_pkg::PRIME_COUNT - 1));
   end

   assign hit = hit_ff;

endmodule

FILE: rtl/ppt_controller.sv
module ppt_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  ppt_pkg::ppt_status_type   status,
   output ppt_pkg::ppt_cmd_type      cmd,
   output logic                      busy,
   output logic                      done
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SETUP = 4'd1;
   localparam logic [3:0] S_BITS  = 4'd2;
   localparam logic [3:0] S_TRIAL = 4'd3;
   localparam logic [3:0] S_MUL   = 4'd4;
   localparam logic [3:0] S_CHECK = 4'd5;
   localparam logic [3:0] S_EXACT = 4'd6;
   localparam logic [3:0] S_NEXT  = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   logic [3:0] state_ff, state_in;

   // sequencing over exponents, root bits and multiplies
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_value = 1'b1;
               state_in       = S_SETUP;
            end
         end
         S_SETUP: begin
            if (status.value_zero) begin
               state_in = S_DONE;
            end else begin
               cmd.init_exp = 1'b1;
               state_in     = S_BITS;
            end
         end
         S_BITS: begin
            cmd.init_bit = 1'b1;
            state_in     = S_TRIAL;
         end
         S_TRIAL: begin
            cmd.start_trial = 1'b1;
            state_in        = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            // candidate too large: drop this bit
            if (status.over) begin
               state_in = S_NEXT;
            end else begin
               cmd.check = 1'b1;
               state_in  = status.pow_last ? S_EXACT : S_MUL;
            end
         end
         S_EXACT: begin
            if (status.exact) begin
               cmd.set_hit = 1'b1;
               state_in    = S_DONE;
            end else begin
               cmd.keep_root = 1'b1;
               state_in      = S_NEXT;
            end
         end
         S_NEXT: begin
            if (!status.bit_last) begin
               cmd.next_bit = 1'b1;
               state_in     = S_TRIAL;
            end else if (!status.exp_last) begin
               cmd.next_exp = 1'b1;
               state_in     = S_BITS;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign done = (state_ff == S_DONE);

endmodule

FILE: rtl/perfect_power_test.sv
// channel   | ports                             | handshake
// ----------+-----------------------------------+------------------------------
// request   | start, busy, req_value            | taken when start & !busy
// response  | rsp_valid, rsp_is_perfect_power   | one-cycle strobe, no back-off
//
// one word is tested at a time; busy stays high until its response is shown
// every prime exponent gets a setup state and a greedy root search, one root bit per trial;
// a trial runs TRIAL, then MUL and CHECK per multiply on the single shared multiplier,
// then EXACT once all p multiplies finish, then NEXT, stopping early once the power passes the value
// zero goes from setup straight to done, and a hit ends the search early;
// synchronous reset returns to idle, no response stall
module perfect_power_test (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [ppt_pkg::VALUE_BITS-1:0]  req_value,
   output logic                            rsp_valid,
   output logic                            rsp_is_perfect_power
);

   ppt_pkg::ppt_cmd_type    cmd;
   ppt_pkg::ppt_status_type status;

   // sequencer
   ppt_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy),
      .done   (rsp_valid)
   );

   // root search and power datapath
   ppt_datapath u_datapath (
      .clock     (clock),
      .req_value (req_value),
      .cmd       (cmd),
      .status    (status),
      .hit       (rsp_is_perfect_power)
   );

endmodule

FILE: rtl/ppt_checker.sv
`include "perfect_power_test_assert.svh"

module ppt_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // a response only ends a word that was taken
   `PPT_ASSERT_NOW(a_rsp_while_busy, clock, reset, rsp_valid, busy)

   // exactly one strobe per word, then back to idle
   `PPT_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid && !busy)

   // an accepted word keeps the block busy
   `PPT_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_valid)

   // reset leaves the block idle and quiet
   `PPT_ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !busy && !rsp_valid)

endmodule

bind perfect_power_test ppt_checker u_ppt_checker (.*);
